>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the packet buffer core.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/pbdf_pkg.sv
`timescale 1ns / 1ps
// Package of the packet buffer: operation codes, field widths, entry type.
// No dependencies.
package pbdf_pkg;

    localparam int FUNC_W = 2;
    localparam int ID_W   = 16;
    localparam int TS_W   = 32;
    localparam int CAP_W  = 9;
    localparam int CNT_W  = 9;

    localparam int DEPTH_DEF = 256;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FWD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0] source;
        logic [ID_W-1:0] destination;
        logic [TS_W-1:0] timestamp;
    } entry_t;

endpackage

>>> rtl/pbdf_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the packet buffer.
// Depends on pbdf_pkg for field widths.
interface pbdf_req_if;
    logic                             valid;
    logic                             ready;
    logic [pbdf_pkg::FUNC_W-1:0]      func;
    logic [pbdf_pkg::ID_W-1:0]        src_id;
    logic [pbdf_pkg::ID_W-1:0]        destination;
    logic [pbdf_pkg::TS_W-1:0]        timestamp;
    logic [pbdf_pkg::TS_W-1:0]        start_time;
    logic [pbdf_pkg::TS_W-1:0]        end_time;

    modport source (output valid, func, src_id, destination, timestamp, start_time,
                    end_time, input ready);
    modport sink (input valid, func, src_id, destination, timestamp, start_time,
                  end_time, output ready);
endinterface

interface pbdf_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             added;
    logic                             forward_valid;
    logic [pbdf_pkg::ID_W-1:0]        out_source;
    logic [pbdf_pkg::ID_W-1:0]        out_destination;
    logic [pbdf_pkg::TS_W-1:0]        out_timestamp;
    logic [pbdf_pkg::CNT_W-1:0]       range_count;

    modport source (output valid, added, forward_valid, out_source, out_destination,
                    out_timestamp, range_count, input ready);
    modport sink (input valid, added, forward_valid, out_source, out_destination,
                  out_timestamp, range_count, output ready);
endinterface

>>> rtl/pbdf_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pbdf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, register the read data every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/packet_buffer_dedup_fifo_core.sv
`timescale 1ns / 1ps
// Packet buffer: bounded FIFO of {source, destination, timestamp} with duplicate filter.
// Add and count walk the stored entries through one RAM read port and one compare
// unit, one entry per cycle. Forward reads the head entry.
// One transaction at a time; ready again once the result sits in the output register.
// rst_n (async, active low) clears pointers, occupancy, sets capacity to 256; RAM kept.
`include "assert_macros.svh"

module packet_buffer_dedup_fifo_core #(
    parameter int DEPTH = pbdf_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pbdf_pkg::CAP_W-1:0]  cfg_wdata,
    pbdf_req_if.sink                    req,
    pbdf_rsp_if.source                  rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > pbdf_pkg::CAP_W) ? OCC_W : pbdf_pkg::CAP_W;
    localparam int ENT_W = $bits(pbdf_pkg::entry_t);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Control state
    logic [1:0]                 state_reg, state_next;
    logic [IDX_W-1:0]           head_reg, head_next;
    logic [IDX_W-1:0]           tail_reg, tail_next;
    logic [OCC_W-1:0]           occ_reg, occ_next;
    logic [pbdf_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [OCC_W-1:0]           cnt_reg, cnt_next;
    logic [OCC_W-1:0]           lim_reg, lim_next;
    logic [IDX_W-1:0]           addr_reg, addr_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic                       out_vld_reg, out_vld_next;

    // Transaction payload and scan results
    logic [pbdf_pkg::FUNC_W-1:0] func_reg;
    pbdf_pkg::entry_t            ent_reg;
    logic [pbdf_pkg::TS_W-1:0]   t0_reg;
    logic [pbdf_pkg::TS_W-1:0]   t1_reg;
    logic                        dup_reg;
    logic [pbdf_pkg::CNT_W-1:0]  match_reg;
    pbdf_pkg::entry_t            fwd_reg;

    // Output register
    logic                        o_added_reg;
    logic                        o_fwd_vld_reg;
    pbdf_pkg::entry_t            o_ent_reg;
    logic [pbdf_pkg::CNT_W-1:0]  o_count_reg;

    logic              accept;
    logic              issue;
    logic              done_fire;
    logic              add_ok;
    logic              fwd_ok;
    logic              evict;
    logic [CMP_W-1:0]  eff_cap;
    logic              ram_we;
    logic [ENT_W-1:0]  ram_rdata;
    pbdf_pkg::entry_t  rd_ent;
    logic              hit_same;
    logic              hit_range;

    assign accept    = req.valid && req.ready;
    assign issue     = (state_reg == ST_SCAN) && (cnt_reg < lim_reg);
    assign done_fire = (state_reg == ST_DONE) && (!out_vld_reg || rsp.ready);
    assign add_ok    = (func_reg == pbdf_pkg::FUNC_ADD) && !dup_reg;
    assign fwd_ok    = (func_reg == pbdf_pkg::FUNC_FWD) && (occ_reg != '0);
    assign ram_we    = done_fire && add_ok;

    // Clamp capacity to [1, DEPTH]
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(DEPTH))
        begin
            eff_cap = CMP_W'(DEPTH);
        end
        else
        begin
            eff_cap = CMP_W'(cap_reg);
        end
    end

    assign evict = CMP_W'(occ_reg) >= eff_cap;

    // Entry store
    pbdf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ent_reg),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Shared compare unit on the entry just read
    assign rd_ent    = pbdf_pkg::entry_t'(ram_rdata);
    assign hit_same  = (rd_ent == ent_reg);
    assign hit_range = (rd_ent.destination == ent_reg.destination)
                       && (rd_ent.timestamp >= t0_reg) && (rd_ent.timestamp <= t1_reg);

    // Sequencer and pointer updates
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        occ_next     = occ_reg;
        cap_next     = cap_reg;
        cnt_next     = cnt_reg;
        lim_next     = lim_reg;
        addr_next    = addr_reg;
        rd_vld_next  = issue;
        out_vld_next = out_vld_reg;

        if (cfg_we)
        begin
            cap_next = cfg_wdata;
        end

        if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    addr_next  = head_reg;
                    case (req.func)
                        pbdf_pkg::FUNC_ADD:   lim_next = occ_reg;
                        pbdf_pkg::FUNC_COUNT: lim_next = occ_reg;
                        pbdf_pkg::FUNC_FWD:   lim_next = OCC_W'(occ_reg != '0);
                        default:              lim_next = '0;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    addr_next = (addr_reg == IDX_W'(DEPTH - 1)) ? '0 : addr_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    state_next   = ST_IDLE;
                    out_vld_next = 1'b1;
                    if ((add_ok && evict) || fwd_ok)
                    begin
                        head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    end
                    if (add_ok)
                    begin
                        tail_next = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                        if (!evict)
                        begin
                            occ_next = occ_reg + 1'b1;
                        end
                    end
                    if (fwd_ok)
                    begin
                        occ_next = occ_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            cap_reg     <= pbdf_pkg::CAP_RESET;
            cnt_reg     <= '0;
            lim_reg     <= '0;
            addr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            occ_reg     <= occ_next;
            cap_reg     <= cap_next;
            cnt_reg     <= cnt_next;
            lim_reg     <= lim_next;
            addr_reg    <= addr_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Capture the transaction, accumulate scan results, load the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg              <= req.func;
            ent_reg.source        <= req.src_id;
            ent_reg.destination   <= req.destination;
            ent_reg.timestamp     <= req.timestamp;
            t0_reg                <= req.start_time;
            t1_reg                <= req.end_time;
            dup_reg               <= 1'b0;
            match_reg             <= '0;
            fwd_reg               <= '0;
        end
        else if (rd_vld_reg)
        begin
            if (hit_same)
            begin
                dup_reg <= 1'b1;
            end
            if (hit_range)
            begin
                match_reg <= match_reg + 1'b1;
            end
            fwd_reg <= rd_ent;
        end

        if (done_fire)
        begin
            o_added_reg   <= add_ok;
            o_fwd_vld_reg <= fwd_ok;
            o_ent_reg     <= fwd_ok ? fwd_reg : '0;
            o_count_reg   <= (func_reg == pbdf_pkg::FUNC_COUNT) ? match_reg : '0;
        end
    end

    // Drive the channels
    assign req.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = out_vld_reg;
    assign rsp.added           = o_added_reg;
    assign rsp.forward_valid   = o_fwd_vld_reg;
    assign rsp.out_source      = o_ent_reg.source;
    assign rsp.out_destination = o_ent_reg.destination;
    assign rsp.out_timestamp   = o_ent_reg.timestamp;
    assign rsp.range_count     = o_count_reg;

    // Checks
    `ASSERT_ALWAYS(a_occ_bound, occ_reg <= OCC_W'(DEPTH), "occupancy above depth")
    `ASSERT_NEXT(a_scan_feed, issue, rd_vld_reg, "issued read produced no compare")
    `ASSERT_IMPLIES(a_write_done, ram_we, state_reg == ST_DONE, "store written outside commit")
    `ASSERT_ALWAYS(a_one_kind, !(rsp.valid && rsp.added && rsp.forward_valid),
                   "result flags both add and forward")

endmodule
